>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define MBROT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define MBROT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> rtl/mbrot_pkg.sv
// Package with the register map, field widths and fixed constants of the escape-time core.
package mbrot_pkg;

  localparam int PIX_W   = 12;
  localparam int LIMIT_W = 16;
  localparam int DIM_W   = 13;
  localparam int DATA_W  = 16;
  localparam int IDX_W   = 2;

  localparam int NUM_W = 15;
  localparam int DEN_W = 14;

  localparam int MAX_DIM = 4096;
  localparam int INT_CAP = 64;

  localparam logic [IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [LIMIT_W-1:0] RST_LIMIT  = 16'd10000;
  localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd1080;

endpackage

>>> rtl/mbrot_map.sv
// Bit-serial long divider that maps a pixel position to a fixed-point coordinate.
module mbrot_map #(
  parameter int FRAC_BITS = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mbrot_pkg::NUM_W-1:0]   num,
  input  logic [mbrot_pkg::DEN_W-1:0]   den,
  input  logic                          is_y,
  output logic                          done,
  output logic [FRAC_BITS+5:0]          coord
);

  localparam int W     = FRAC_BITS + 6;
  localparam int NW    = mbrot_pkg::NUM_W;
  localparam int DW    = mbrot_pkg::DEN_W;
  localparam int STEPS = NW + FRAC_BITS;
  localparam int CW    = $clog2(STEPS);
  localparam int SW    = FRAC_BITS + 8;

  localparam logic signed [SW-1:0] OFF_X = $signed(SW'(5) << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] OFF_Y = $signed(SW'(1) << FRAC_BITS);
  localparam logic signed [SW-1:0] WMAX  = $signed((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] WMIN  = -WMAX - SW'(1);

  logic [NW-1:0]    num_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    rem_nxt;
  logic [STEPS-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic             isy_r;

  logic [DW:0]             trial;
  logic                    ge;
  logic [NW-1:0]           ipart;
  logic [6:0]              ipart_c;
  logic signed [SW-1:0]    val;
  logic signed [SW-1:0]    diff;

  always_comb begin
    trial   = {rem_r, num_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      isy_r <= is_y;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[STEPS-2:0], ge};
    end
  end

  always_comb begin
    ipart   = quo_r[STEPS-1:FRAC_BITS];
    ipart_c = (ipart > NW'(mbrot_pkg::INT_CAP)) ? 7'(mbrot_pkg::INT_CAP) : ipart[6:0];
    val     = $signed(SW'({ipart_c, quo_r[FRAC_BITS-1:0]}));
    diff    = val - (isy_r ? OFF_Y : OFF_X);
    if (diff > WMAX) begin
      coord = WMAX[W-1:0];
    end else if (diff < WMIN) begin
      coord = WMIN[W-1:0];
    end else begin
      coord = diff[W-1:0];
    end
  end

  assign done = done_r;

endmodule

>>> rtl/mbrot_mul.sv
// Signed fixed-point multiplier (multi-pass above 31 fraction bits) with floor rounding, shared by all products.
module mbrot_mul #(
  parameter int FRAC_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [FRAC_BITS+5:0] a,
  input  logic [FRAC_BITS+5:0] b,
  output logic                 done,
  output logic [FRAC_BITS+5:0] p
);

  localparam int W      = FRAC_BITS + 6;
  localparam int MAG    = FRAC_BITS + 1;
  localparam int DIG    = (MAG > 32) ? 2 : 1;
  localparam int H      = (MAG + DIG - 1) / DIG;
  localparam int UW     = DIG * H;
  localparam int PASSES = DIG * DIG;
  localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int AW     = 2 * UW + 4;

  logic [UW-1:0]  ua_r;
  logic [UW-1:0]  ub_r;
  logic           neg_r;
  logic [PW-1:0]  pass_r;
  logic           run_r;
  logic [2*H-1:0] pp_r;
  logic [1:0]     sh_r;
  logic           ppv_r;
  logic           last_r;
  logic [AW-1:0]  acc_r;
  logic [AW-1:0]  acc_nxt;
  logic           done_r;

  logic [W-1:0] abs_a;
  logic [W-1:0] abs_b;
  logic         di;
  logic         dj;
  logic [H-1:0] da;
  logic [H-1:0] db;
  logic [W-1:0] q;
  logic         rem;

  always_comb begin
    abs_a   = a[W-1] ? (W'(0) - a) : a;
    abs_b   = b[W-1] ? (W'(0) - b) : b;
    di      = (DIG > 1) ? pass_r[PW-1] : 1'b0;
    dj      = (DIG > 1) ? pass_r[0] : 1'b0;
    da      = ua_r[int'(di) * H +: H];
    db      = ub_r[int'(dj) * H +: H];
    acc_nxt = acc_r + (AW'(pp_r) << (int'(sh_r) * H));
    q       = acc_r[FRAC_BITS +: W];
    rem     = |acc_r[FRAC_BITS-1:0];
    p       = neg_r ? (W'(0) - q - W'(rem)) : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ppv_r  <= 1'b0;
      last_r <= 1'b0;
      done_r <= 1'b0;
      pass_r <= '0;
    end else begin
      done_r <= ppv_r && last_r;
      ppv_r  <= run_r;
      last_r <= run_r && (pass_r == PW'(PASSES - 1));
      if (start) begin
        run_r  <= 1'b1;
        pass_r <= '0;
      end else if (run_r) begin
        pass_r <= pass_r + PW'(1);
        if (pass_r == PW'(PASSES - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= da * db;
    sh_r <= {1'b0, di} + {1'b0, dj};
    if (start) begin
      ua_r  <= UW'(abs_a[MAG-1:0]);
      ub_r  <= UW'(abs_b[MAG-1:0]);
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
    end else if (ppv_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;

endmodule

>>> rtl/mandelbrot_escape_time_pixel_core.sv
// Top level of the Mandelbrot escape-time core: sequencer, iteration datapath and registers.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_pixel_x, in_pixel_y, in_tile_last
//   out      output     out_valid/out_stall out_escape_count, out_result_last
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// Each pixel's coordinates are mapped in the serial divider, x and then y, and each
// escape iteration then forms its three products in turn in the one shared multiplier
// (in several passes per product above 31 fraction bits), with a hand-off between steps.
// The core takes a new beat only when idle; a finished result waits in the output register.
// Synchronous reset returns the sequencer to idle and restores the register defaults.
module mandelbrot_escape_time_pixel_core #(
  parameter int FRAC_BITS  = 26,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbrot_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [mbrot_pkg::PIX_W-1:0]       in_pixel_y,
  input  logic                              in_tile_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbrot_pkg::LIMIT_W-1:0]     out_escape_count,
  output logic                              out_result_last,
  input  logic                              cfg_we,
  input  logic [mbrot_pkg::IDX_W-1:0]       cfg_index,
  input  logic [mbrot_pkg::DATA_W-1:0]      cfg_data
);

  localparam int W     = FRAC_BITS + 6;
  localparam int CNT_W = (COUNT_BITS < mbrot_pkg::LIMIT_W) ? COUNT_BITS : mbrot_pkg::LIMIT_W;
  localparam int DW    = mbrot_pkg::DIM_W;
  localparam int NW    = mbrot_pkg::NUM_W;
  localparam int PW    = mbrot_pkg::PIX_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [W-1:0]   TWO_FX  = $signed(W'(2) << FRAC_BITS);
  localparam logic signed [W-1:0]   NTWO_FX = -TWO_FX;
  localparam logic signed [W:0]     FOUR_FX = $signed((W + 1)'(4) << FRAC_BITS);
  localparam logic signed [W+1:0]   SMAX    = $signed((W + 2)'((W + 2)'(1) << (W - 1)) - (W + 2)'(1));
  localparam logic signed [W+1:0]   SMIN    = -SMAX - (W + 2)'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVX  = 3'd1;
  localparam logic [2:0] S_DIVY  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MXX   = 3'd4;
  localparam logic [2:0] S_MYY   = 3'd5;
  localparam logic [2:0] S_MXY   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [W-1:0] sat_w(input logic signed [W+1:0] v);
    logic [W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (32'(d) > mbrot_pkg::MAX_DIM) begin
      r = DW'(mbrot_pkg::MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  logic [mbrot_pkg::LIMIT_W-1:0] cfg_limit_r;
  logic [DW-1:0]                 cfg_width_r;
  logic [DW-1:0]                 cfg_height_r;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [PW-1:0]       py_r;
  logic                last_r;
  logic signed [W-1:0] cx_r;
  logic signed [W-1:0] cy_r;
  logic signed [W-1:0] x_r;
  logic signed [W-1:0] y_r;
  logic signed [W-1:0] x_nxt;
  logic signed [W-1:0] y_nxt;
  logic signed [W-1:0] xx_r;
  logic signed [W-1:0] yy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_last_r;

  logic [DW-1:0]                wd;
  logic [DW-1:0]                hd;
  logic [CNT_W-1:0]             lim;
  logic                         accept;
  logic                         stop;
  logic                         esc4;
  logic                         out_load;
  logic                         map_start;
  logic [NW-1:0]                map_num;
  logic [mbrot_pkg::DEN_W-1:0]  map_den;
  logic                         map_is_y;
  logic                         map_done;
  logic [W-1:0]                 map_coord;
  logic                         mul_start;
  logic [W-1:0]                 mul_a;
  logic [W-1:0]                 mul_b;
  logic                         mul_done;
  logic signed [W-1:0]          mul_p;

  always_comb begin
    wd  = clamp_dim(cfg_width_r);
    hd  = clamp_dim(cfg_height_r);
    lim = (cfg_limit_r > mbrot_pkg::LIMIT_W'(COUNT_MAX)) ? COUNT_MAX : cfg_limit_r[CNT_W-1:0];

    accept   = in_valid && (state_r == S_IDLE);
    stop     = (cnt_r >= lim) || (x_r >= TWO_FX) || (x_r <= NTWO_FX)
               || (y_r >= TWO_FX) || (y_r <= NTWO_FX);
    esc4     = ($signed({xx_r[W-1], xx_r}) + $signed({mul_p[W-1], mul_p})) >= FOUR_FX;
    out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

    x_nxt = sat_w($signed({{2{xx_r[W-1]}}, xx_r}) - $signed({{2{yy_r[W-1]}}, yy_r})
                  + $signed({{2{cx_r[W-1]}}, cx_r}));
    y_nxt = sat_w($signed({mul_p[W-1], mul_p, 1'b0}) + $signed({{2{cy_r[W-1]}}, cy_r}));

    map_start = accept || ((state_r == S_DIVX) && map_done);
    map_is_y  = (state_r != S_IDLE);
    map_num   = map_is_y ? NW'({py_r, 1'b0}) : NW'(NW'(in_pixel_x) * NW'(7));
    map_den   = map_is_y ? {1'b0, hd} : {wd, 1'b0};

    mul_start = ((state_r == S_CHECK) && !stop) || ((state_r == S_MXX) && mul_done)
                || ((state_r == S_MYY) && mul_done && !esc4);
    mul_a     = (state_r == S_MXX) ? y_r : x_r;
    mul_b     = (state_r == S_CHECK) ? x_r : y_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (map_done) begin
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (map_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stop ? S_DONE : S_MXX;
      end
      S_MXX: begin
        if (mul_done) begin
          state_nxt = S_MYY;
        end
      end
      S_MYY: begin
        if (mul_done) begin
          state_nxt = esc4 ? S_DONE : S_MXY;
        end
      end
      S_MXY: begin
        if (mul_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cfg_limit_r  <= mbrot_pkg::RST_LIMIT;
      cfg_width_r  <= mbrot_pkg::RST_WIDTH;
      cfg_height_r <= mbrot_pkg::RST_HEIGHT;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          mbrot_pkg::CFG_LIMIT:  cfg_limit_r  <= cfg_data;
          mbrot_pkg::CFG_WIDTH:  cfg_width_r  <= cfg_data[DW-1:0];
          mbrot_pkg::CFG_HEIGHT: cfg_height_r <= cfg_data[DW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      py_r   <= in_pixel_y;
      last_r <= in_tile_last;
    end
    if ((state_r == S_DIVX) && map_done) begin
      cx_r <= map_coord;
    end
    if ((state_r == S_DIVY) && map_done) begin
      cy_r  <= map_coord;
      x_r   <= '0;
      y_r   <= '0;
      cnt_r <= '0;
    end
    if ((state_r == S_MXX) && mul_done) begin
      xx_r <= mul_p;
    end
    if ((state_r == S_MYY) && mul_done) begin
      yy_r <= mul_p;
    end
    if ((state_r == S_MXY) && mul_done) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (out_load) begin
      out_count_r <= cnt_r;
      out_last_r  <= last_r;
    end
  end

  mbrot_map #(
    .FRAC_BITS(FRAC_BITS)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .start (map_start),
    .num   (map_num),
    .den   (map_den),
    .is_y  (map_is_y),
    .done  (map_done),
    .coord (map_coord)
  );

  mbrot_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = mbrot_pkg::LIMIT_W'(out_count_r);
  assign out_result_last  = out_last_r;

endmodule

>>> rtl/mbrot_checker.sv
// Port-level checker of the escape-time core and its bind to the top level.
`include "assert_macros.svh"

module mbrot_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [mbrot_pkg::PIX_W-1:0]   in_pixel_x,
  input logic [mbrot_pkg::PIX_W-1:0]   in_pixel_y,
  input logic                          in_tile_last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mbrot_pkg::LIMIT_W-1:0] out_escape_count,
  input logic                          out_result_last,
  input logic                          cfg_we,
  input logic [mbrot_pkg::IDX_W-1:0]   cfg_index,
  input logic [mbrot_pkg::DATA_W-1:0]  cfg_data
);

  `MBROT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !in_stall && !out_valid)
  `MBROT_ASSERT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `MBROT_ASSERT(a_no_instant_result, clk, rst_n, in_valid && !in_stall |=> !$rose(out_valid))
  `MBROT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_escape_count) && $stable(out_result_last))

endmodule

bind mandelbrot_escape_time_pixel_core mbrot_checker u_mbrot_checker (.*);

>>> dv/mandelbrot_escape_time_pixel_core_test.sv
// Self-checking testbench for the Mandelbrot escape-time core with a bit-exact escape counter.
module mandelbrot_escape_time_pixel_core_test;

  localparam int FRAC = 26;
  localparam longint ONE_FX = 64'sd1 << FRAC;
  localparam longint WORD_HI = (64'sd1 << 31) - 1;
  localparam longint WORD_LO = -(64'sd1 << 31);
  localparam logic [mbrot_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_AT = 50;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [mbrot_pkg::PIX_W-1:0] x;
    logic [mbrot_pkg::PIX_W-1:0] y;
    logic                        last;
  } pixel_t;

  typedef struct packed {
    logic [mbrot_pkg::LIMIT_W-1:0] count;
    logic                          last;
  } escape_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [mbrot_pkg::PIX_W-1:0]   in_pixel_x = '0;
  logic [mbrot_pkg::PIX_W-1:0]   in_pixel_y = '0;
  logic                          in_tile_last = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [mbrot_pkg::LIMIT_W-1:0] out_escape_count;
  logic                          out_result_last;
  logic                          cfg_we = 1'b0;
  logic [mbrot_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [mbrot_pkg::DATA_W-1:0]  cfg_data = '0;

  logic [mbrot_pkg::LIMIT_W-1:0] cur_limit = mbrot_pkg::RST_LIMIT;
  logic [mbrot_pkg::DIM_W-1:0]   cur_w = mbrot_pkg::RST_WIDTH;
  logic [mbrot_pkg::DIM_W-1:0]   cur_h = mbrot_pkg::RST_HEIGHT;

  pixel_t  pixels_waiting[$];
  escape_t counts_due[$];
  pixel_t  next_pixel;
  escape_t due;
  int      tx_idle_pct = 8;
  int      rx_idle_pct = 74;
  int      mismatches = 0;
  int      results_seen = 0;
  int      hold_left = 0;
  logic    hold_done = 1'b0;
  int      cycles = 0;

  mandelbrot_escape_time_pixel_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_tile_last     (in_tile_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count),
    .out_result_last  (out_result_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint clamp_dim(logic [mbrot_pkg::DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > mbrot_pkg::MAX_DIM) return mbrot_pkg::MAX_DIM;
    return d;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  function automatic longint map_axis(longint num, longint den, longint offset);
    longint whole;
    whole = num / den;
    if (whole > mbrot_pkg::INT_CAP) whole = mbrot_pkg::INT_CAP;
    return sat_word((whole << FRAC) + (((num % den) << FRAC) / den) - offset);
  endfunction

  function automatic logic [mbrot_pkg::LIMIT_W-1:0] escape_count_of(
      logic [mbrot_pkg::PIX_W-1:0] px, logic [mbrot_pkg::PIX_W-1:0] py);
    longint cx, cy, x, y, xx, yy, xy;
    int unsigned n;
    cx = map_axis(longint'(px) * 7, 2 * clamp_dim(cur_w), 5 * (ONE_FX / 2));
    cy = map_axis(longint'(py) * 2, clamp_dim(cur_h), ONE_FX);
    x = 0;
    y = 0;
    n = 0;
    while (n < cur_limit) begin
      if (x >= 2 * ONE_FX || x <= -2 * ONE_FX || y >= 2 * ONE_FX || y <= -2 * ONE_FX) break;
      xx = (x * x) >>> FRAC;
      yy = (y * y) >>> FRAC;
      if (xx + yy >= 4 * ONE_FX) break;
      xy = (x * y) >>> FRAC;
      x = sat_word(xx - yy + cx);
      y = sat_word(2 * xy + cy);
      n++;
    end
    return n[mbrot_pkg::LIMIT_W-1:0];
  endfunction

  function automatic logic [mbrot_pkg::DATA_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return mbrot_pkg::DATA_W'($urandom);
      default: return mbrot_pkg::DATA_W'($urandom_range(1, mbrot_pkg::MAX_DIM));
    endcase
  endfunction

  function automatic logic [mbrot_pkg::PIX_W-1:0] pick_coord(logic [mbrot_pkg::DIM_W-1:0] d);
    if ($urandom_range(0, 4) == 0) return mbrot_pkg::PIX_W'($urandom);
    return mbrot_pkg::PIX_W'($urandom_range(0, 32'(clamp_dim(d) - 1)));
  endfunction

  task automatic add_pixel(logic [mbrot_pkg::PIX_W-1:0] x, logic [mbrot_pkg::PIX_W-1:0] y,
                           logic last);
    pixels_waiting.push_back(pixel_t'{x, y, last});
  endtask

  task automatic write_reg(logic [mbrot_pkg::IDX_W-1:0] idx, logic [mbrot_pkg::DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbrot_pkg::CFG_LIMIT:  cur_limit = val[mbrot_pkg::LIMIT_W-1:0];
      mbrot_pkg::CFG_WIDTH:  cur_w = val[mbrot_pkg::DIM_W-1:0];
      mbrot_pkg::CFG_HEIGHT: cur_h = val[mbrot_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pixels_waiting.size() != 0 || in_valid || counts_due.size() != 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch on %s: expected %0d, got %0d.", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        counts_due.push_back(escape_t'{escape_count_of(in_pixel_x, in_pixel_y), in_tile_last});
      end
      if (pixels_waiting.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_pixel = pixels_waiting.pop_front();
        in_valid <= 1'b1;
        in_pixel_x <= next_pixel.x;
        in_pixel_y <= next_pixel.y;
        in_tile_last <= next_pixel.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (counts_due.size() == 0) begin
        flag_mismatch("a beat with no pixel outstanding", 0, out_escape_count);
      end else begin
        due = counts_due.pop_front();
        if (out_escape_count !== due.count) begin
          flag_mismatch("escape_count", due.count, out_escape_count);
        end
        if (out_result_last !== due.last) begin
          flag_mismatch("result_last", due.last, out_result_last);
        end
      end
    end
  end

  // The slowest correct run stays well below this, the one pixel that runs out the
  // default limit included.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_pixel(12'd0, 12'd0, 1'b0);
    add_pixel(12'd4095, 12'd4095, 1'b1);
    add_pixel(12'd480, 12'd270, 1'b0);
    add_pixel(12'd1371, 12'd540, 1'b1);
    settle();

    write_reg(mbrot_pkg::CFG_LIMIT, 16'd0);
    write_reg(mbrot_pkg::CFG_WIDTH, 16'd0);
    write_reg(mbrot_pkg::CFG_HEIGHT, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'h1234);
    add_pixel(12'd0, 12'd0, 1'b1);
    add_pixel(12'd4095, 12'd0, 1'b0);
    add_pixel(12'd0, 12'd4095, 1'b1);
    add_pixel(12'hAAA, 12'h555, 1'b0);
    add_pixel(12'h555, 12'hAAA, 1'b1);
    settle();

    write_reg(mbrot_pkg::CFG_LIMIT, 16'hFFFF);
    write_reg(mbrot_pkg::CFG_WIDTH, 16'd1);
    write_reg(mbrot_pkg::CFG_HEIGHT, 16'd1);
    add_pixel(12'd0, 12'd0, 1'b0);
    add_pixel(12'd1, 12'd0, 1'b1);
    add_pixel(12'd1, 12'd1, 1'b0);
    add_pixel(12'd2, 12'd4095, 1'b1);
    add_pixel(12'd4095, 12'd2048, 1'b0);
    settle();

    write_reg(mbrot_pkg::CFG_LIMIT, 16'd1);
    write_reg(mbrot_pkg::CFG_WIDTH, 16'd4096);
    write_reg(mbrot_pkg::CFG_HEIGHT, 16'd4096);
    add_pixel(12'd2048, 12'd2048, 1'b1);
    add_pixel(12'd0, 12'd0, 1'b0);
    settle();

    write_reg(mbrot_pkg::CFG_LIMIT, 16'd31);
    write_reg(mbrot_pkg::CFG_WIDTH, 16'd16);
    write_reg(mbrot_pkg::CFG_HEIGHT, 16'd16);
    add_pixel(12'd8, 12'd8, 1'b0);
    add_pixel(12'd4095, 12'd4095, 1'b1);
    add_pixel(12'd5, 12'd8, 1'b0);
    add_pixel(12'd10, 12'd4, 1'b1);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        tx_idle_pct = 74;
        rx_idle_pct = 8;
      end
      if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(mbrot_pkg::CFG_LIMIT, mbrot_pkg::DATA_W'($urandom_range(0, 40)));
      write_reg(mbrot_pkg::CFG_WIDTH, random_dim());
      write_reg(mbrot_pkg::CFG_HEIGHT, random_dim());
      repeat (17) add_pixel(pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 7) == 0);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && counts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/mbrot_pkg.sv
rtl/mbrot_map.sv
rtl/mbrot_mul.sv
rtl/mandelbrot_escape_time_pixel_core.sv
rtl/mbrot_checker.sv
dv/mandelbrot_escape_time_pixel_core_test.sv
